// File: src/lse_pkg.sv
// Shared types, constants and tables of the pruned log-sum-exp block.
`default_nettype none
package lse_pkg;

  localparam int unsigned MAX_VALUES_DEF = 64;

  localparam logic signed [31:0] NEG_INF       = 32'sh8000_0000;
  localparam logic signed [31:0] POS_MAX       = 32'sh7fff_ffff;
  localparam logic signed [31:0] THR_RESET     = -32'sd655360;
  localparam logic        [30:0] LOG2E_Q30     = 31'd1549082005;
  localparam logic        [31:0] LN2_Q32       = 32'd2977044472;
  localparam logic        [32:0] ONE_Q32       = 33'h1_0000_0000;
  localparam logic         [4:0] SER_TERMS     = 5'd24;
  localparam logic        [16:0] EXP_K_LIMIT   = 17'd40;
  localparam logic         [4:0] NORM_E_LIMIT  = 5'd30;
  localparam logic         [3:0] SQ_LAST       = 4'd15;
  localparam logic         [0:0] REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic signed [31:0] log_value;
    logic               last_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] log_sum;
    logic               overflowed;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD,
    ST_EVAL,
    ST_EXP_T,
    ST_EXP_A,
    ST_SER_MUL,
    ST_SER_DIVM,
    ST_SER_DIVC,
    ST_EXP_ADD,
    ST_NORM,
    ST_SQ,
    ST_LN_MUL,
    ST_OUT,
    ST_OUT_INF
  } fsm_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIN_INIT,
    OP_READ,
    OP_EVAL,
    OP_EXP_T,
    OP_EXP_A,
    OP_SER_MUL,
    OP_SER_DIVM,
    OP_SER_DIVC,
    OP_EXP_ADD,
    OP_NORM_INIT,
    OP_NORM,
    OP_SQ_INIT,
    OP_SQ,
    OP_LN_MUL,
    OP_OUT,
    OP_OUT_INF
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic max_neginf;
    logic scan_done;
    logic term_use;
    logic k_big;
    logic ser_last;
    logic norm_more;
    logic sq_last;
    logic out_free;
  } dp_sts_t;

  // floor((2^36 - 1) / i): the quotient estimate is then low by at most one.
  function automatic logic [35:0] recip_q36(input logic [4:0] i);
    logic [35:0] m;
    case (i)
      5'd1:    m = 36'd68719476735;
      5'd2:    m = 36'd34359738367;
      5'd3:    m = 36'd22906492245;
      5'd4:    m = 36'd17179869183;
      5'd5:    m = 36'd13743895347;
      5'd6:    m = 36'd11453246122;
      5'd7:    m = 36'd9817068105;
      5'd8:    m = 36'd8589934591;
      5'd9:    m = 36'd7635497415;
      5'd10:   m = 36'd6871947673;
      5'd11:   m = 36'd6247225157;
      5'd12:   m = 36'd5726623061;
      5'd13:   m = 36'd5286113595;
      5'd14:   m = 36'd4908534052;
      5'd15:   m = 36'd4581298449;
      5'd16:   m = 36'd4294967295;
      5'd17:   m = 36'd4042322160;
      5'd18:   m = 36'd3817748707;
      5'd19:   m = 36'd3616814565;
      5'd20:   m = 36'd3435973836;
      5'd21:   m = 36'd3272356987;
      5'd22:   m = 36'd3123612578;
      5'd23:   m = 36'd2987803336;
      5'd24:   m = 36'd2863311530;
      default: m = 36'd0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: src/lse_ctrl.sv
// Sequencing state machine of the pruned log-sum-exp block.
`default_nettype none
module lse_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_stall,
  input  wire lse_pkg::dp_sts_t sts,
  output lse_pkg::dp_cmd_t     cmd
);
  import lse_pkg::*;

  fsm_t state_r, state_nxt;
  logic in_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc && in_last) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = sts.max_neginf ? ST_OUT_INF : ST_RD;
      ST_RD:       state_nxt = sts.scan_done ? ST_NORM : ST_EVAL;
      ST_EVAL:     state_nxt = sts.term_use ? ST_EXP_T : ST_RD;
      ST_EXP_T:    state_nxt = ST_EXP_A;
      ST_EXP_A:    state_nxt = sts.k_big ? ST_RD : ST_SER_MUL;
      ST_SER_MUL:  state_nxt = ST_SER_DIVM;
      ST_SER_DIVM: state_nxt = ST_SER_DIVC;
      ST_SER_DIVC: state_nxt = sts.ser_last ? ST_EXP_ADD : ST_SER_MUL;
      ST_EXP_ADD:  state_nxt = ST_RD;
      ST_NORM:     if (!sts.norm_more) state_nxt = ST_SQ;
      ST_SQ:       if (sts.sq_last) state_nxt = ST_LN_MUL;
      ST_LN_MUL:   state_nxt = ST_OUT;
      ST_OUT:      if (sts.out_free) state_nxt = ST_IDLE;
      ST_OUT_INF:  if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      ST_IDLE:     if (in_acc) cmd.op = OP_LOAD;
      ST_CHECK:    cmd.op = OP_FIN_INIT;
      ST_RD:       cmd.op = sts.scan_done ? OP_NORM_INIT : OP_READ;
      ST_EVAL:     cmd.op = OP_EVAL;
      ST_EXP_T:    cmd.op = OP_EXP_T;
      ST_EXP_A:    if (!sts.k_big) cmd.op = OP_EXP_A;
      ST_SER_MUL:  cmd.op = OP_SER_MUL;
      ST_SER_DIVM: cmd.op = OP_SER_DIVM;
      ST_SER_DIVC: cmd.op = OP_SER_DIVC;
      ST_EXP_ADD:  cmd.op = OP_EXP_ADD;
      ST_NORM:     cmd.op = sts.norm_more ? OP_NORM : OP_SQ_INIT;
      ST_SQ:       cmd.op = OP_SQ;
      ST_LN_MUL:   cmd.op = OP_LN_MUL;
      ST_OUT:      if (sts.out_free) cmd.op = OP_OUT;
      ST_OUT_INF:  if (sts.out_free) cmd.op = OP_OUT_INF;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/lse_dp.sv
// Datapath of the pruned log-sum-exp block: value store, exp series and log unit.
`default_nettype none
module lse_dp #(
  parameter int unsigned MAX_VALUES = lse_pkg::MAX_VALUES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lse_pkg::dp_cmd_t   cmd,
  output lse_pkg::dp_sts_t        sts,
  input  wire lse_pkg::in_item_t  in_data,
  input  wire logic signed [31:0] threshold,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lse_pkg::out_item_t      out_data
);
  import lse_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_VALUES);
  localparam int unsigned CW    = $clog2(MAX_VALUES + 1);
  localparam int unsigned SUM_W = 34 + AW;

  logic [31:0] mem [MAX_VALUES];

  logic [CW-1:0]      cnt_r, scan_r;
  logic signed [31:0] max_r;
  logic               ovf_r, lead_r, out_valid_r;
  out_item_t          out_r;

  logic signed [31:0] rd_r;
  logic [31:0]        n_r, a_r, x_r;
  logic [32:0]        t_r, term_r;
  logic [67:0]        pd_r;
  logic [34:0]        even_r, odd_r;
  logic [4:0]         ser_r, e_r;
  logic [SUM_W-1:0]   sum_r, m_r;
  logic [31:0]        sq_r;
  logic [3:0]         sqc_r;
  logic [15:0]        frac_r;
  logic [20:0]        ln_r;

  // Classification of the value just read from the store.
  logic               is_inf, is_lead;
  logic signed [32:0] diff;
  logic signed [32:0] thr_ext;
  always_comb begin
    is_inf  = (rd_r == NEG_INF);
    is_lead = !lead_r && (rd_r == max_r);
    diff    = {rd_r[31], rd_r} - {max_r[31], max_r};
    thr_ext = $signed({threshold[31], threshold});
  end

  logic [62:0] prod_t;
  logic [47:0] prod_a;
  logic [64:0] prod_s;
  logic [31:0] q0, r_div, q;
  logic [36:0] qi;
  logic [34:0] e_diff, e_term;
  logic [63:0] prod_sq;
  logic [52:0] ln_prod;
  logic signed [32:0] res_w;
  logic signed [31:0] res_sat;
  always_comb begin
    prod_t  = 63'(n_r * LOG2E_Q30);
    prod_a  = t_r[15:0] * LN2_Q32;
    prod_s  = term_r * a_r;
    q0      = pd_r[67:36];
    qi      = q0 * ser_r;
    r_div   = x_r - qi[31:0];
    q       = (r_div >= {27'd0, ser_r}) ? q0 + 32'd1 : q0;
    e_diff  = (even_r >= odd_r) ? even_r - odd_r : 35'd0;
    e_term  = e_diff >> t_r[21:16];
    prod_sq = sq_r * sq_r;
    ln_prod = 53'({e_r, frac_r}) * LN2_Q32 + 53'h8000_0000;
    res_w   = {max_r[31], max_r} + {12'd0, ln_r};
    res_sat = (res_w > 33'sd2147483647) ? POS_MAX : res_w[31:0];
  end

  always_comb begin
    sts.max_neginf = (max_r == NEG_INF);
    sts.scan_done  = (scan_r == cnt_r);
    sts.term_use   = !is_inf && !is_lead && (diff > thr_ext);
    sts.k_big      = (t_r[32:16] >= EXP_K_LIMIT);
    sts.ser_last   = (ser_r == SER_TERMS);
    sts.norm_more  = (e_r < NORM_E_LIMIT) && (m_r[SUM_W-1:33] != '0);
    sts.sq_last    = (sqc_r == SQ_LAST);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Set state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      max_r       <= NEG_INF;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!out_stall) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          if (cnt_r < CW'(MAX_VALUES)) begin
            cnt_r <= cnt_r + CW'(1);
            if (in_data.log_value > max_r) max_r <= in_data.log_value;
          end else begin
            ovf_r <= 1'b1;
          end
        end
        OP_OUT, OP_OUT_INF: begin
          out_valid_r <= 1'b1;
          cnt_r       <= '0;
          max_r       <= NEG_INF;
          ovf_r       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && cnt_r < CW'(MAX_VALUES)) begin
      mem[cnt_r[AW-1:0]] <= in_data.log_value;
    end
    if (cmd.op == OP_READ) begin
      rd_r <= mem[scan_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_FIN_INIT: begin
        sum_r  <= SUM_W'(ONE_Q32);
        lead_r <= 1'b0;
        scan_r <= '0;
      end
      OP_READ: scan_r <= scan_r + CW'(1);
      OP_EVAL: begin
        if (!is_inf && is_lead) lead_r <= 1'b1;
        n_r <= 32'(-diff);
      end
      OP_EXP_T: t_r <= prod_t[62:30];
      OP_EXP_A: begin
        a_r    <= prod_a[47:16];
        term_r <= ONE_Q32;
        even_r <= 35'(ONE_Q32);
        odd_r  <= '0;
        ser_r  <= 5'd1;
      end
      OP_SER_MUL:  x_r  <= prod_s[63:32];
      OP_SER_DIVM: pd_r <= x_r * recip_q36(ser_r);
      OP_SER_DIVC: begin
        term_r <= {1'b0, q};
        if (ser_r[0]) odd_r <= odd_r + 35'(q);
        else          even_r <= even_r + 35'(q);
        ser_r <= ser_r + 5'd1;
      end
      OP_EXP_ADD: sum_r <= sum_r + SUM_W'(e_term);
      OP_NORM_INIT: begin
        m_r <= sum_r;
        e_r <= '0;
      end
      OP_NORM: begin
        m_r <= m_r >> 1;
        e_r <= e_r + 5'd1;
      end
      OP_SQ_INIT: begin
        sq_r   <= m_r[32:1];
        sqc_r  <= '0;
        frac_r <= '0;
      end
      OP_SQ: begin
        if (prod_sq[63]) begin
          sq_r   <= prod_sq[63:32];
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          sq_r   <= prod_sq[62:31];
          frac_r <= {frac_r[14:0], 1'b0};
        end
        sqc_r <= sqc_r + 4'd1;
      end
      OP_LN_MUL: ln_r <= ln_prod[52:32];
      OP_OUT: begin
        out_r.log_sum    <= res_sat;
        out_r.overflowed <= ovf_r;
      end
      OP_OUT_INF: begin
        out_r.log_sum    <= NEG_INF;
        out_r.overflowed <= ovf_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_VALUES)) else $error("value count beyond store depth");
  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT || cmd.op == OP_OUT_INF) |=> out_valid_r && cnt_r == '0)
    else $error("result not registered or set not cleared");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT || cmd.op == OP_OUT_INF) |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a waiting result");
  a_ser_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SER_DIVC) |-> (ser_r >= 5'd1 && ser_r <= SER_TERMS))
    else $error("series index out of range");

endmodule
`default_nettype wire

// File: src/log_sum_exp_pruned.sv
// Top level of the pruned log-sum-exp block: handshakes, register port, control and datapath.
// Loading takes one request per cycle; in_stall stays low while the block is idle.
// After the request marked last, the block scans the N stored values, runs the exp
// series for the P values that add a term and makes E normalizing shifts, then raises
// out_valid; a kept value whose exponential underflows skips the series, and an all
// minus infinity set skips the scan. A term runs 24 series steps of multiply and divide.
// Synchronous active-low reset clears the set, the threshold (to -10.0) and the output.
`default_nettype none
module log_sum_exp_pruned #(
  parameter int unsigned MAX_VALUES = lse_pkg::MAX_VALUES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lse_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lse_pkg::out_item_t     out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import lse_pkg::*;

  // The prune threshold is the only register. A term is kept when its
  // difference from the maximum is strictly greater than the threshold.
  logic signed [31:0] thr_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
      thr_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? thr_r : 32'd0;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences a finished set: scan the store, run the exp
  // series for each kept term, normalize the sum and extract its logarithm.
  lse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_value),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the store, the running maximum and the output
  // register, so a waiting result does not block loading of the next set.
  lse_dp #(
    .MAX_VALUES (MAX_VALUES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .threshold (thr_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
